>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the envelope checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, off during reset.
`define ARE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Expression holds at every edge outside reset.
`define ARE_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

>>> rtl/core/are_pkg.sv
// ----------------------------------------------------------------------------
// are_pkg
// Register indexes and curve codes for the attack/release envelope.
// ----------------------------------------------------------------------------
package are_pkg;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ATTACK  = 2'd0,
      CSR_RELEASE = 2'd1,
      CSR_CURVE   = 2'd2
   } csr_index_type;

   typedef logic [1:0] curve_type;

   localparam curve_type CURVE_SQRT   = 2'd1;
   localparam curve_type CURVE_SQUARE = 2'd3;

endpackage

>>> rtl/core/attack_release_envelope.sv
// ----------------------------------------------------------------------------
// attack_release_envelope
// Envelope gain (unsigned Q1.FRAC_BITS) for a position along a span. Takes
// one position per clock and answers each one at a sustained rate of one
// result per clock. Each position passes the entry register, the restoring
// divider, one quotient bit per stage, the square root unit, one root bit
// per stage, and the output register; every item goes through both units
// so the order is kept whatever the curve mode. The response
// side cannot stall: rsp_valid is a one-cycle strobe and must be taken.
// busy is high only during reset. The user writes registers through the csr
// channel only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module attack_release_envelope
   import are_pkg::*;
#(
   parameter int FRAC_BITS = 16
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [FRAC_BITS:0]        req_position,
   output logic                      rsp_valid,
   output logic [FRAC_BITS:0]        rsp_gain,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [FRAC_BITS:0]        csr_data
);

   localparam int F = FRAC_BITS;
   localparam int W = FRAC_BITS + 1;
   localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};

   // configuration
   logic [W-1:0] attack_ff;
   logic [W-1:0] release_ff;
   curve_type    curve_ff;

   assign csr_ready = ~reset;
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= '0;
         release_ff <= '0;
         curve_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ATTACK:  attack_ff  <= csr_data;
            CSR_RELEASE: release_ff <= csr_data;
            CSR_CURVE:   curve_ff   <= csr_data[1:0];
            default:     ;
         endcase
      end
   end

   // entry: pick the portion and set up numerator and divisor
   logic         in_accept;
   logic         atk_hit;
   logic         rel_hit;
   logic [W:0]   rel_sum;
   logic [W-1:0] rel_num;
   logic [W-1:0] num_in;
   logic [W-1:0] den_in;
   logic         pass_in;

   always_comb begin
      in_accept = start & ~busy;
      atk_hit   = (attack_ff != '0) && (req_position < attack_ff);
      rel_sum   = {1'b0, req_position} + {1'b0, release_ff};
      rel_hit   = (release_ff != '0) && (rel_sum > {1'b0, ONE});
      rel_num   = (req_position <= ONE) ? (ONE - req_position) : '0;
      num_in    = atk_hit ? req_position : rel_num;
      den_in    = atk_hit ? attack_ff : release_ff;
      pass_in   = ~(atk_hit | rel_hit);
   end

   // divider pipeline; index 0 is the entry register
   logic         div_valid_ff [0:F];
   logic         div_pass_ff  [0:F];
   curve_type    div_mode_ff  [0:F];
   logic [W-1:0] div_rem_ff   [0:F];
   logic [W-1:0] div_den_ff   [0:F];
   logic [F-1:0] div_quo_ff   [0:F];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else begin
         div_valid_ff[0] <= in_accept;
      end
      div_pass_ff[0] <= pass_in;
      div_mode_ff[0] <= curve_ff;
      div_rem_ff[0]  <= num_in;
      div_den_ff[0]  <= den_in;
      div_quo_ff[0]  <= '0;
   end

   // remainder stays below the divisor, so one shift-compare-subtract a stage
   for (genvar k = 1; k <= F; k++) begin : g_div
      logic [W:0]   shift_in;
      logic [W:0]   diff_in;
      logic         ge_in;
      logic [W-1:0] rem_in;

      always_comb begin
         shift_in = {div_rem_ff[k-1], 1'b0};
         diff_in  = shift_in - {1'b0, div_den_ff[k-1]};
         ge_in    = shift_in >= {1'b0, div_den_ff[k-1]};
         rem_in   = ge_in ? diff_in[W-1:0] : shift_in[W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k] <= 1'b0;
         end else begin
            div_valid_ff[k] <= div_valid_ff[k-1];
         end
         div_pass_ff[k] <= div_pass_ff[k-1];
         div_mode_ff[k] <= div_mode_ff[k-1];
         div_rem_ff[k]  <= rem_in;
         div_den_ff[k]  <= div_den_ff[k-1];
         div_quo_ff[k]  <= {div_quo_ff[k-1][F-2:0], ge_in};
      end
   end

   // square root pipeline over ramp << F, one root bit a stage
   logic         sq_valid_ff [1:F];
   logic         sq_pass_ff  [1:F];
   curve_type    sq_mode_ff  [1:F];
   logic [F-1:0] sq_ramp_ff  [1:F];
   logic [F-1:0] sq_root_ff  [1:F];
   logic [F+1:0] sq_rem_ff   [1:F];

   for (genvar j = 1; j <= F; j++) begin : g_sqrt
      logic         prev_valid;
      logic         prev_pass;
      curve_type    prev_mode;
      logic [F-1:0] prev_ramp;
      logic [F-1:0] prev_root;
      logic [F+1:0] prev_rem;
      logic [2*F-1:0] rad_in;
      logic [F+3:0] cur_in;
      logic [F+3:0] trial_in;
      logic [F+3:0] diff_in;
      logic         ge_in;
      logic [F+1:0] rem_in;

      if (j == 1) begin : g_first
         assign prev_valid = div_valid_ff[F];
         assign prev_pass  = div_pass_ff[F];
         assign prev_mode  = div_mode_ff[F];
         assign prev_ramp  = div_quo_ff[F];
         assign prev_root  = '0;
         assign prev_rem   = '0;
      end else begin : g_next
         assign prev_valid = sq_valid_ff[j-1];
         assign prev_pass  = sq_pass_ff[j-1];
         assign prev_mode  = sq_mode_ff[j-1];
         assign prev_ramp  = sq_ramp_ff[j-1];
         assign prev_root  = sq_root_ff[j-1];
         assign prev_rem   = sq_rem_ff[j-1];
      end

      always_comb begin
         rad_in   = {prev_ramp, {F{1'b0}}};
         cur_in   = {prev_rem, rad_in[2*F-2*j+1 -: 2]};
         trial_in = {2'b00, prev_root, 2'b01};
         diff_in  = cur_in - trial_in;
         ge_in    = cur_in >= trial_in;
         rem_in   = ge_in ? diff_in[F+1:0] : cur_in[F+1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j] <= 1'b0;
         end else begin
            sq_valid_ff[j] <= prev_valid;
         end
         sq_pass_ff[j] <= prev_pass;
         sq_mode_ff[j] <= prev_mode;
         sq_ramp_ff[j] <= prev_ramp;
         sq_root_ff[j] <= {prev_root[F-2:0], ge_in};
         sq_rem_ff[j]  <= rem_in;
      end
   end

   // shaping and output register
   logic [2*F-1:0] prod_in;
   logic [W-1:0]   gain_in;
   logic           rsp_valid_ff;
   logic [W-1:0]   rsp_gain_ff;

   always_comb begin
      prod_in = sq_ramp_ff[F] * sq_ramp_ff[F];
      if (sq_pass_ff[F]) begin
         gain_in = ONE;
      end else begin
         unique case (sq_mode_ff[F])
            CURVE_SQRT:   gain_in = {1'b0, sq_root_ff[F]};
            CURVE_SQUARE: gain_in = {1'b0, prod_in[2*F-1:F]};
            default:      gain_in = {1'b0, sq_ramp_ff[F]};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sq_valid_ff[F];
      end
      rsp_gain_ff <= gain_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gain  = rsp_gain_ff;

endmodule

>>> rtl/core/are_checker.sv
// ----------------------------------------------------------------------------
// are_checker
// Port-level checks on the envelope: timing of responses, gain range and unity gain with both ramps disabled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module are_checker
   import are_pkg::*;
#(
   parameter int FRAC_BITS = 16
)(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [FRAC_BITS:0]        rsp_gain,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [CSR_INDEX_BITS-1:0] csr_index,
   input logic [FRAC_BITS:0]        csr_data
);

   localparam int LAT = 2 * FRAC_BITS + 2;
   localparam int CW  = $clog2(LAT + 1);
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [CW-1:0] since_rst_ff;
   logic          atk_zero_ff;
   logic          rel_zero_ff;
   logic          req_accept;

   assign req_accept = start && !busy;

   // counts cycles since reset, saturating at the pipeline latency
   always_ff @(posedge clock) begin
      if (reset) begin
         since_rst_ff <= '0;
      end else if (since_rst_ff != CW'(LAT)) begin
         since_rst_ff <= since_rst_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atk_zero_ff <= 1'b1;
         rel_zero_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ATTACK) begin
            atk_zero_ff <= (csr_data == '0);
         end else if (csr_index == CSR_RELEASE) begin
            rel_zero_ff <= (csr_data == '0);
         end
      end
   end

   `ARE_ASSERT_IMPLY(a_rsp_timing, clock, reset, since_rst_ff == CW'(LAT), rsp_valid == $past(req_accept, LAT), "response does not follow its transaction at the fixed latency")
   `ARE_ASSERT_ALWAYS(a_gain_range, clock, reset, !rsp_valid || (rsp_gain <= ONE), "gain above 1.0")
   `ARE_ASSERT_IMPLY(a_flat_gain, clock, reset, rsp_valid && atk_zero_ff && rel_zero_ff, rsp_gain == ONE, "gain not 1.0 with both ramps disabled")
   `ARE_ASSERT_IMPLY(a_no_rsp_after_reset, clock, reset, rsp_valid, !$past(reset), "response right after reset")

endmodule

bind attack_release_envelope are_checker #(.FRAC_BITS(FRAC_BITS)) u_are_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_gain     (rsp_gain),
   .csr_valid    (csr_valid),
   .csr_ready    (csr_ready),
   .csr_index    (csr_index),
   .csr_data     (csr_data)
);

>>> test/attack_release_envelope_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attack_release_envelope_tb
// Self-checking bench for the envelope gain block. A clocked driver sends
// positions in bursts from a pending queue and predicts each gain when the
// transaction is accepted. A clocked monitor compares every gain strobe with
// the oldest prediction. Settings change only while the pipeline is empty.
// ----------------------------------------------------------------------------
module attack_release_envelope_tb;
   import are_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam logic [63:0] UNITY = 64'd1 << FRAC_BITS;
   localparam int DRAIN_CYCLES = 2 * FRAC_BITS + 8;
   localparam curve_type CURVE_LINEAR = 2'd0;
   localparam curve_type CURVE_LINEAR_ALT = 2'd2;

   typedef struct {
      logic [FRAC_BITS:0] position;
      logic [FRAC_BITS:0] gain;
   } gain_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [FRAC_BITS:0] req_position = '0;
   logic rsp_valid;
   logic [FRAC_BITS:0] rsp_gain;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_ATTACK;
   logic [FRAC_BITS:0] csr_data = '0;

   // copy of the register file, updated on each accepted csr write
   logic [FRAC_BITS:0] attack_q = '0;
   logic [FRAC_BITS:0] release_q = '0;
   curve_type curve_q = CURVE_LINEAR;

   logic [FRAC_BITS:0] position_q[$];
   gain_entry_type gain_q[$];
   int errors = 0;
   int burst_left = 0;
   int gap_left = 0;

   attack_release_envelope #(.FRAC_BITS(FRAC_BITS)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_gain(rsp_gain),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 40) begin
         $display("ERROR %0t: %s", $realtime, msg);
      end
   endtask

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] cand;
      root = '0;
      for (int b = FRAC_BITS; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= v) root = cand;
      end
      return root;
   endfunction

   function automatic logic [FRAC_BITS:0] shaped(input logic [63:0] ramp);
      if (curve_q == CURVE_SQRT) return (FRAC_BITS+1)'(floor_sqrt(ramp << FRAC_BITS));
      if (curve_q == CURVE_SQUARE) return (FRAC_BITS+1)'((ramp * ramp) >> FRAC_BITS);
      return (FRAC_BITS+1)'(ramp);
   endfunction

   function automatic logic [FRAC_BITS:0] envelope_gain(input logic [FRAC_BITS:0] pos);
      logic [63:0] t;
      logic [63:0] att;
      logic [63:0] rel;
      logic [63:0] num;
      t = 64'(pos);
      att = 64'(attack_q);
      rel = 64'(release_q);
      // attack wins when both portions contain t
      if (att != 0 && t < att) return shaped((t << FRAC_BITS) / att);
      if (rel != 0 && t + rel > UNITY) begin
         num = (t <= UNITY) ? UNITY - t : 64'd0;
         return shaped((num << FRAC_BITS) / rel);
      end
      return (FRAC_BITS+1)'(UNITY);
   endfunction

   // driver: bursts of transactions with random gaps, start held while busy
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            gain_q.push_back('{req_position, envelope_gain(req_position)});
         end
         if (start && busy) begin
            // hold the current transaction
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (position_q.size() > 0) begin
            start <= 1'b1;
            req_position <= position_q.pop_front();
            if (burst_left == 0) burst_left = $urandom_range(1, 40);
            burst_left--;
            if (burst_left == 0) begin
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results cannot be held off, so every strobe is checked here
   always @(posedge clock) begin
      gain_entry_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (gain_q.size() == 0) begin
            report_mismatch($sformatf("gain %0d with no transaction pending", rsp_gain));
         end else begin
            want = gain_q.pop_front();
            if (rsp_gain !== want.gain) begin
               report_mismatch($sformatf("position %0d: gain %0d, expected %0d",
                  want.position, rsp_gain, want.gain));
            end
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [FRAC_BITS:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ATTACK: attack_q = value;
         CSR_RELEASE: release_q = value;
         default: curve_q = value[1:0];
      endcase
   endtask

   task automatic write_settings(input logic [FRAC_BITS:0] att, input logic [FRAC_BITS:0] rel,
                                 input curve_type curve);
      write_csr(CSR_ATTACK, att);
      write_csr(CSR_RELEASE, rel);
      write_csr(CSR_CURVE, {{(FRAC_BITS-1){1'b0}}, curve});
   endtask

   // wait for all pending transactions and their gains, then let the pipe empty
   task automatic wait_drained();
      int cycles;
      cycles = 0;
      while (position_q.size() > 0 || start) @(posedge clock);
      while (gain_q.size() > 0 && cycles < 200) begin
         cycles++;
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (gain_q.size() > 0) begin
         report_mismatch($sformatf("%0d transactions never answered", gain_q.size()));
         gain_q.delete();
      end
   endtask

   function automatic logic [FRAC_BITS:0] pick_length();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 1;
         2: return (FRAC_BITS+1)'(UNITY);
         3: return {(FRAC_BITS+1){1'b1}};
         4: return (FRAC_BITS+1)'($urandom_range(1, 32'(UNITY - 1)));
         5: return (FRAC_BITS+1)'($urandom_range(0, 32'(2 * UNITY - 1)));
         default: return (FRAC_BITS+1)'($urandom_range(1024, 32'(UNITY / 2)));
      endcase
   endfunction

   function automatic logic [FRAC_BITS:0] pick_position();
      case ($urandom_range(0, 9))
         6: return (FRAC_BITS+1)'($urandom);
         7: return (FRAC_BITS+1)'(32'(attack_q) + $urandom_range(0, 4) - 2);
         8: return (FRAC_BITS+1)'(UNITY - 64'(release_q) + 64'($urandom_range(0, 4)) - 2);
         9: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return (FRAC_BITS+1)'(UNITY - 1);
               2: return (FRAC_BITS+1)'(UNITY);
               3: return (FRAC_BITS+1)'(UNITY + 1);
               default: return {(FRAC_BITS+1){1'b1}};
            endcase
         end
         default: return (FRAC_BITS+1)'($urandom_range(0, 32'(UNITY)));
      endcase
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: every position gets full gain
      position_q = '{0, 65536, 131071, 12345};
      wait_drained();

      // quarter-span ramps on both ends, alternate linear code
      write_settings(17'd16384, 17'd16384, CURVE_LINEAR_ALT);
      position_q = '{0, 16383, 16384, 49151, 49152, 49153, 65535, 65537};
      wait_drained();

      // overlapping portions, release longer than the span, sqrt shaping
      write_settings(17'd65536, 17'h1FFFF, CURVE_SQRT);
      position_q = '{0, 1, 40000, 65535, 65536, 131071};
      wait_drained();

      // attack longer than the span, one-lsb release, square shaping
      write_settings(17'h1FFFF, 17'd1, CURVE_SQUARE);
      position_q = '{0, 65535, 65536, 131070, 131071};
      wait_drained();

      for (int phase = 0; phase < 10; phase++) begin
         write_settings(pick_length(), pick_length(), curve_type'(phase % 4));
         repeat (110) position_q.push_back(pick_position());
         wait_drained();
      end

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
